[rtl/core/tdmpr_pkg.sv]
// ----------------------------------------------------------------------------
// tdmpr_pkg: shared types and constants for the triac power regulator
// Event, gesture and mode codes, the regulator state record and the phase
// firing delay table.
// ----------------------------------------------------------------------------
package tdmpr_pkg;

	// event codes
	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_EDGE    = 2'd1;
	localparam logic [1:0] ACT_GESTURE = 2'd2;

	// gesture codes
	localparam logic [1:0] GST_NONE   = 2'd0;
	localparam logic [1:0] GST_CLICK  = 2'd1;
	localparam logic [1:0] GST_DOUBLE = 2'd2;
	localparam logic [1:0] GST_LONG   = 2'd3;

	// operating modes
	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_PHASE   = 2'd1;
	localparam logic [1:0] MODE_BURST   = 2'd2;
	localparam logic [1:0] MODE_SERVICE = 2'd3;

	localparam logic [3:0] MAX_LEVEL       = 4'd10;
	localparam logic [3:0] SERVICE_PHASE_LEVEL = 4'd2;
	localparam logic [7:0] BLANK_TICKS_RESET = 8'd50;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] level;
		logic [7:0] delay_count;
		logic [3:0] cycle_count;
		logic       gate;
		logic [1:0] service_choice;
		logic [3:0] saved_level;
		logic [1:0] saved_mode;
	} reg_state_t;

	typedef struct packed {
		logic       gate_on;
		logic [1:0] run_mode;
		logic [3:0] power_level;
	} result_t;

	// firing delay in ticks after the zero-cross edge, by level
	function automatic logic [7:0] fire_delay(input logic [3:0] lvl);
		logic [7:0] d;
		case (lvl)
			4'd0: d = 8'd255;
			4'd1: d = 8'd203;
			4'd2: d = 8'd180;
			4'd3: d = 8'd161;
			4'd4: d = 8'd144;
			4'd5: d = 8'd128;
			4'd6: d = 8'd111;
			4'd7: d = 8'd94;
			4'd8: d = 8'd75;
			4'd9: d = 8'd52;
			default: d = 8'd0;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/tdmpr_step.sv]
// ----------------------------------------------------------------------------
// tdmpr_step: next-state logic of the regulator
// Applies one event (tick, zero-cross edge or gesture) to the regulator state.
// ----------------------------------------------------------------------------
module tdmpr_step (
	input  tdmpr_pkg::reg_state_t cur,
	input  logic [1:0]            action,
	input  logic                  comparator_low,
	input  logic [1:0]            gesture,
	input  logic [7:0]            blank_ticks,
	output tdmpr_pkg::reg_state_t nxt
);

	logic       run_active;
	logic [1:0] toggled_choice;
	logic [3:0] stepped_level;

	assign run_active = (cur.mode == tdmpr_pkg::MODE_PHASE) ||
		(cur.mode == tdmpr_pkg::MODE_BURST);
	assign stepped_level = (cur.level < tdmpr_pkg::MAX_LEVEL) ? cur.level + 4'd1 : 4'd1;

	always_comb begin
		toggled_choice = cur.service_choice;
		if (gesture == tdmpr_pkg::GST_CLICK) begin
			if (cur.service_choice == tdmpr_pkg::MODE_PHASE)
				toggled_choice = tdmpr_pkg::MODE_BURST;
			else if (cur.service_choice == tdmpr_pkg::MODE_BURST)
				toggled_choice = tdmpr_pkg::MODE_PHASE;
		end
	end

	always_comb begin
		nxt = cur;
		case (action)
			tdmpr_pkg::ACT_TICK: begin
				if (cur.delay_count != 8'd0) begin
					if (cur.mode == tdmpr_pkg::MODE_PHASE)
						nxt.gate = 1'b0;
					nxt.delay_count = cur.delay_count - 8'd1;
				end else if (cur.mode == tdmpr_pkg::MODE_PHASE) begin
					nxt.gate = 1'b1;
				end
			end
			tdmpr_pkg::ACT_EDGE: begin
				if (cur.mode == tdmpr_pkg::MODE_PHASE) begin
					nxt.delay_count = tdmpr_pkg::fire_delay(cur.level);
				end else if (cur.mode == tdmpr_pkg::MODE_BURST) begin
					// edges are blanked while the counter runs
					if (cur.delay_count == 8'd0 && comparator_low) begin
						nxt.gate = cur.cycle_count < cur.level;
						nxt.cycle_count = (cur.cycle_count < tdmpr_pkg::MAX_LEVEL) ?
							cur.cycle_count + 4'd1 : 4'd0;
						nxt.delay_count = blank_ticks;
					end
				end else begin
					nxt.gate = 1'b0;
				end
			end
			tdmpr_pkg::ACT_GESTURE: begin
				if (cur.mode == tdmpr_pkg::MODE_OFF) begin
					if (gesture == tdmpr_pkg::GST_LONG) begin
						nxt.mode = (cur.saved_mode == tdmpr_pkg::MODE_PHASE ||
							cur.saved_mode == tdmpr_pkg::MODE_BURST) ?
							cur.saved_mode : tdmpr_pkg::MODE_PHASE;
						nxt.level = (cur.saved_level != 4'd0) ?
							cur.saved_level : tdmpr_pkg::MAX_LEVEL;
					end else if (gesture == tdmpr_pkg::GST_DOUBLE) begin
						nxt.service_choice = cur.saved_mode;
						nxt.mode = tdmpr_pkg::MODE_SERVICE;
						if (cur.saved_mode == tdmpr_pkg::MODE_PHASE)
							nxt.level = tdmpr_pkg::SERVICE_PHASE_LEVEL;
						else if (cur.saved_mode == tdmpr_pkg::MODE_BURST)
							nxt.level = tdmpr_pkg::MAX_LEVEL;
					end
				end else if (run_active) begin
					if (gesture == tdmpr_pkg::GST_CLICK) begin
						nxt.level = stepped_level;
					end else if (gesture == tdmpr_pkg::GST_LONG) begin
						nxt.saved_level = cur.level;
						nxt.mode = tdmpr_pkg::MODE_OFF;
						nxt.level = 4'd0;
					end
				end else begin
					if (gesture == tdmpr_pkg::GST_LONG) begin
						nxt.saved_mode = cur.service_choice;
						nxt.level = 4'd0;
						nxt.service_choice = 2'd0;
						nxt.mode = tdmpr_pkg::MODE_OFF;
					end else begin
						nxt.service_choice = toggled_choice;
						// level mirrors the service choice
						if (toggled_choice == tdmpr_pkg::MODE_PHASE)
							nxt.level = tdmpr_pkg::SERVICE_PHASE_LEVEL;
						else if (toggled_choice == tdmpr_pkg::MODE_BURST)
							nxt.level = tdmpr_pkg::MAX_LEVEL;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

[rtl/core/triac_dual_mode_power_regulator.sv]
// ----------------------------------------------------------------------------
// triac_dual_mode_power_regulator: phase-angle and burst-fire triac control
// Takes one event per transfer and returns the gate, mode and level after it.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | action, comparator_low, gesture
//  out     | out_valid / out_ready| gate_on, run_mode, power_level
//  cfg     | cfg_valid / cfg_ready| cfg_data (zero-cross blanking ticks)
//
//  One event per cycle while in_ready is high; an event is held in the input
//  register, then its state update is held in the result register.
//  A two-entry result buffer lets input transfers continue while out_ready is
//  low; in_ready drops only when both entries are full and an event is held.
//  Reset clears the regulator state and the valid flags and sets the blanking
//  count to 50; cfg_ready is always high.
// ----------------------------------------------------------------------------
module triac_dual_mode_power_regulator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic       comparator_low,
	input  logic [1:0] gesture,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       gate_on,
	output logic [1:0] run_mode,
	output logic [3:0] power_level,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic                  valid_s1;
	logic [1:0]            action_s1;
	logic                  comparator_low_s1;
	logic [1:0]            gesture_s1;
	logic [7:0]            blank_ticks_q;
	tdmpr_pkg::reg_state_t state_q;
	tdmpr_pkg::reg_state_t state_nxt;
	tdmpr_pkg::result_t    result;
	tdmpr_pkg::result_t    out_q;
	tdmpr_pkg::result_t    skid_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;
	logic                  fire;
	logic                  pop;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && !skid_valid_q;
	assign in_ready  = !valid_s1 || fire;
	assign pop       = out_valid_q && out_ready;

	tdmpr_step u_step (
		.cur            (state_q),
		.action         (action_s1),
		.comparator_low (comparator_low_s1),
		.gesture        (gesture_s1),
		.blank_ticks    (blank_ticks_q),
		.nxt            (state_nxt)
	);

	assign result.gate_on     = state_nxt.gate;
	assign result.run_mode    = state_nxt.mode;
	assign result.power_level = state_nxt.level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_ticks_q <= tdmpr_pkg::BLANK_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			blank_ticks_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1         <= action;
			comparator_low_s1 <= comparator_low;
			gesture_s1        <= gesture;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// result register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || pop) begin
				out_valid_q  <= skid_valid_q || fire;
				skid_valid_q <= 1'b0;
			end else if (fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (fire) begin
			skid_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign gate_on     = out_q.gate_on;
	assign run_mode    = out_q.run_mode;
	assign power_level = out_q.power_level;

endmodule
